// ===== hdl/hpvf_pkg.sv =====
// Package of the hysteresis peak and valley finder.
// Holds the shared types, record kind codes and default parameter values.
// Depends on nothing; every other file of the block uses it.
package hpvf_pkg;

	// Default number of record slots; at most RECORD_SLOTS-1 records are emitted.
	localparam int RECORD_SLOTS_DEF = 64;

	// Field widths fixed by the sample and record formats.
	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 16;
	localparam int INDEX_W  = 32;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 6;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR  = 2'd1;

	// Kind of an emitted record.
	typedef enum logic [KIND_W-1:0] {
		KIND_START  = 2'd0,
		KIND_PEAK   = 2'd1,
		KIND_VALLEY = 2'd2
	} kind_t;

	// Tracker phase, one-hot.
	typedef enum logic [4:0] {
		PH_REFERENCE  = 5'b00001,
		PH_WAIT_START = 5'b00010,
		PH_TREND      = 5'b00100,
		PH_RISING     = 5'b01000,
		PH_FALLING    = 5'b10000
	} phase_t;

	// Threshold settings handed from the register file to the tracker.
	typedef struct packed {
		logic [THR_W-1:0] start_thr;
		logic [THR_W-1:0] peak_thr;
	} cfg_t;

	// One result record.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [INDEX_W-1:0]         index;
		kind_t                      kind;
		logic [SLOT_W-1:0]          slot;
	} rec_t;

endpackage

// ===== hdl/hpvf_sample_if.sv =====
// Sample input channel of the peak and valley finder: valid, ready and payload.
// Depends on hpvf_pkg for the field widths.
interface hpvf_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hpvf_pkg::SAMPLE_W-1:0] sample;
	logic                                 restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);
endinterface

// ===== hdl/hpvf_record_if.sv =====
// Record output channel of the peak and valley finder: valid, ready and payload.
// Depends on hpvf_pkg for the field widths.
interface hpvf_record_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hpvf_pkg::SAMPLE_W-1:0] record_value;
	logic [hpvf_pkg::INDEX_W-1:0]         record_index;
	logic [hpvf_pkg::KIND_W-1:0]          record_kind;
	logic [hpvf_pkg::SLOT_W-1:0]          record_slot;

	modport source (output valid, output record_value, output record_index,
		output record_kind, output record_slot, input ready);
	modport sink (input valid, input record_value, input record_index,
		input record_kind, input record_slot, output ready);
endinterface

// ===== hdl/hpvf_cfg_if.sv =====
// Configuration write channel of the peak and valley finder.
// Depends on hpvf_pkg for the index and data widths.
interface hpvf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hpvf_pkg::CFG_IDX_W-1:0] index;
	logic [hpvf_pkg::THR_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/hpvf_cfg_regs.sv =====
// Threshold register file of the peak and valley finder.
// Depends on hpvf_pkg and hpvf_cfg_if.
module hpvf_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	hpvf_cfg_if.sink        cfg,
	output hpvf_pkg::cfg_t  thr
);

	hpvf_pkg::cfg_t thr_q;

	// Writes are always taken; indexes beyond the list are ignored.
	assign cfg.ready = 1'b1;
	assign thr = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == hpvf_pkg::CFG_START_THR) begin
				thr_q.start_thr <= cfg.data;
			end else if (cfg.index == hpvf_pkg::CFG_PEAK_THR) begin
				thr_q.peak_thr <= cfg.data;
			end
		end
	end

endmodule

// ===== hdl/hpvf_tracker.sv =====
// Five-phase peak and valley tracker: state registers and next-state logic.
// Consumes one registered sample per step and flags a record to emit.
// Depends on hpvf_pkg.
module hpvf_tracker #(
	parameter int RECORD_SLOTS = hpvf_pkg::RECORD_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic signed [hpvf_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 restart,
	input  hpvf_pkg::cfg_t                       thr,
	output logic                                 emit,
	output hpvf_pkg::rec_t                       rec
);

	localparam int CntW = $clog2(RECORD_SLOTS);
	localparam logic [CntW-1:0] LastCnt = CntW'(RECORD_SLOTS - 1);

	hpvf_pkg::phase_t                     phase_q, phase_e, phase_n;
	logic signed [hpvf_pkg::SAMPLE_W-1:0] ref_q, ref_e, ref_n;
	logic signed [hpvf_pkg::SAMPLE_W-1:0] max_q, max_e, max_n;
	logic signed [hpvf_pkg::SAMPLE_W-1:0] min_q, min_e, min_n;
	logic [hpvf_pkg::INDEX_W-1:0]         max_idx_q, max_idx_e, max_idx_n;
	logic [hpvf_pkg::INDEX_W-1:0]         min_idx_q, min_idx_e, min_idx_n;
	logic [hpvf_pkg::INDEX_W-1:0]         cnt_q, cnt_e;
	logic [CntW-1:0]                      rec_cnt_q, rec_cnt_e;
	logic                                 want;

	// Differences are 17 bits wide, so they are exact.
	logic signed [hpvf_pkg::SAMPLE_W:0] s17, d_ref, d_max, d_min, pt17;
	logic [hpvf_pkg::SAMPLE_W:0]        abs_ref, st17;

	// A restart clears the state before the sample is handled.
	always_comb begin
		phase_e   = restart ? hpvf_pkg::PH_REFERENCE : phase_q;
		ref_e     = restart ? '0 : ref_q;
		max_e     = restart ? '0 : max_q;
		min_e     = restart ? '0 : min_q;
		max_idx_e = restart ? '0 : max_idx_q;
		min_idx_e = restart ? '0 : min_idx_q;
		cnt_e     = restart ? '0 : cnt_q;
		rec_cnt_e = restart ? '0 : rec_cnt_q;
	end

	// Next state and record selection for the current sample.
	always_comb begin
		phase_n   = phase_e;
		ref_n     = ref_e;
		max_n     = max_e;
		min_n     = min_e;
		max_idx_n = max_idx_e;
		min_idx_n = min_idx_e;
		want      = 1'b0;
		rec.value = sample;
		rec.index = cnt_e;
		rec.kind  = hpvf_pkg::KIND_START;
		rec.slot  = hpvf_pkg::SLOT_W'(rec_cnt_e);
		s17       = {sample[hpvf_pkg::SAMPLE_W-1], sample};
		pt17      = $signed({1'b0, thr.peak_thr});
		st17      = {1'b0, thr.start_thr};
		d_ref     = s17 - {ref_e[hpvf_pkg::SAMPLE_W-1], ref_e};
		abs_ref   = d_ref[hpvf_pkg::SAMPLE_W] ? unsigned'(-d_ref) : unsigned'(d_ref);
		d_max     = '0;
		d_min     = '0;
		unique case (phase_e)
			hpvf_pkg::PH_REFERENCE: begin
				ref_n   = sample;
				phase_n = hpvf_pkg::PH_WAIT_START;
			end
			hpvf_pkg::PH_WAIT_START: begin
				if (abs_ref > st17) begin
					ref_n   = sample;
					want    = 1'b1;
					phase_n = hpvf_pkg::PH_TREND;
				end
			end
			hpvf_pkg::PH_TREND: begin
				if ($signed(abs_ref) > pt17) begin
					if (d_ref > 0) begin
						max_n     = sample;
						max_idx_n = cnt_e;
						phase_n   = hpvf_pkg::PH_RISING;
					end else begin
						min_n     = sample;
						min_idx_n = cnt_e;
						phase_n   = hpvf_pkg::PH_FALLING;
					end
				end
			end
			hpvf_pkg::PH_RISING: begin
				if (sample > max_e) begin
					max_n     = sample;
					max_idx_n = cnt_e;
				end
				d_max = {max_n[hpvf_pkg::SAMPLE_W-1], max_n} - s17;
				if (d_max > pt17) begin
					want      = 1'b1;
					rec.value = max_n;
					rec.index = max_idx_n;
					rec.kind  = hpvf_pkg::KIND_PEAK;
					min_n     = sample;
					min_idx_n = cnt_e;
					phase_n   = hpvf_pkg::PH_FALLING;
				end
			end
			hpvf_pkg::PH_FALLING: begin
				if (sample < min_e) begin
					min_n     = sample;
					min_idx_n = cnt_e;
				end
				d_min = s17 - {min_n[hpvf_pkg::SAMPLE_W-1], min_n};
				if (d_min > pt17) begin
					want      = 1'b1;
					rec.value = min_n;
					rec.index = min_idx_n;
					rec.kind  = hpvf_pkg::KIND_VALLEY;
					max_n     = sample;
					max_idx_n = cnt_e;
					phase_n   = hpvf_pkg::PH_RISING;
				end
			end
			default: begin
				// Unreachable codes only advance the sample count.
				phase_n = phase_e;
			end
		endcase
		// Records beyond the last slot are dropped.
		emit = want && (rec_cnt_e != LastCnt);
	end

	// State update on every sample step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= hpvf_pkg::PH_REFERENCE;
			ref_q     <= '0;
			max_q     <= '0;
			min_q     <= '0;
			max_idx_q <= '0;
			min_idx_q <= '0;
			cnt_q     <= '0;
			rec_cnt_q <= '0;
		end else if (step) begin
			phase_q   <= phase_n;
			ref_q     <= ref_n;
			max_q     <= max_n;
			min_q     <= min_n;
			max_idx_q <= max_idx_n;
			min_idx_q <= min_idx_n;
			cnt_q     <= cnt_e + 1'b1;
			rec_cnt_q <= emit ? rec_cnt_e + 1'b1 : rec_cnt_e;
		end
	end

	// The emitted record count never passes the last slot.
	a_rec_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rec_cnt_q <= LastCnt)
		else $error("record count passed the last slot");

	// A restarted step leaves exactly one sample counted.
	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && restart |=> cnt_q == 1)
		else $error("sample count not restarted");

	// A peak leaves the tracker following the minimum from the current sample.
	a_peak_switch: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && rec.kind == hpvf_pkg::KIND_PEAK
		|=> phase_q == hpvf_pkg::PH_FALLING && min_q == $past(sample))
		else $error("peak did not switch to falling");

endmodule

// ===== hdl/hysteresis_peak_valley_finder_top.sv =====
// Top level of the hysteresis peak and valley finder.
// A record reaches the channel through the input register and then the record register.
// Throughput: one sample per cycle while the record channel is ready; the tracker
// state loop is closed by combinational logic between the input and record registers.
// Reset: arst_n clears phase, counters and thresholds at once; restart clears the tracker.
// Depends on hpvf_pkg, the channel interfaces, hpvf_cfg_regs and hpvf_tracker.
module hysteresis_peak_valley_finder_top #(
	parameter int RECORD_SLOTS = hpvf_pkg::RECORD_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hpvf_sample_if.sink   samples,
	hpvf_record_if.source records,
	hpvf_cfg_if.sink      cfg
);

	logic                                 valid_s1;
	logic signed [hpvf_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                 restart_s1;
	logic                                 adv_s1;
	logic                                 emit;
	logic                                 out_valid_q;
	hpvf_pkg::rec_t                       rec, rec_q;
	hpvf_pkg::cfg_t                       thr;

	hpvf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.thr    (thr)
	);

	// The registered sample moves on when the record register is free or being taken.
	assign adv_s1        = valid_s1 && (!out_valid_q || records.ready);
	assign samples.ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1  <= samples.sample;
			restart_s1 <= samples.restart;
		end
	end

	hpvf_tracker #(
		.RECORD_SLOTS (RECORD_SLOTS)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.sample  (sample_s1),
		.restart (restart_s1),
		.thr     (thr),
		.emit    (emit),
		.rec     (rec)
	);

	// Record register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= emit;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			rec_q <= rec;
		end
	end

	assign records.valid        = out_valid_q;
	assign records.record_value = rec_q.value;
	assign records.record_index = rec_q.index;
	assign records.record_kind  = rec_q.kind;
	assign records.record_slot  = rec_q.slot;

	// A sample step that emits leaves a record waiting in the next cycle.
	a_emit_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit |=> records.valid)
		else $error("emitted record not presented");

	// A pending record that is not taken blocks the input register.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !records.ready |-> !adv_s1)
		else $error("sample advanced over a pending record");

	// A record that is not taken stays valid and unchanged.
	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && !records.ready |=> records.valid && $stable(rec_q))
		else $error("pending record changed before its transfer");

endmodule

// ===== bench/hysteresis_peak_valley_finder_top_test.sv =====
// Self-checking bench for the hysteresis peak and valley finder top level.
// Drives directed and random sample streams, tracks the expected records with its own tracker
// copy and compares every record transfer. Depends on hpvf_pkg, the channel interfaces, the RTL.
module hysteresis_peak_valley_finder_top_test;

	localparam int RECORD_SLOTS  = hpvf_pkg::RECORD_SLOTS_DEF;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int SEGMENTS      = 6;
	localparam int SEG_ITEMS     = 170;
	localparam int DIR_ROWS      = 22;
	localparam hpvf_pkg::rec_t NO_REC = '0;

	// A row of the directed table either sends one sample or sets both thresholds.
	typedef enum logic {
		ROW_SAMPLE,
		ROW_THRESH
	} row_op_t;

	typedef struct packed {
		row_op_t        op;
		logic [15:0]    smp;       // sample, or start threshold on a threshold row
		logic [15:0]    aux;       // peak threshold on a threshold row
		logic           restart;
		logic           typed;     // the expected result is given in the row itself
		logic           typed_has;
		hpvf_pkg::rec_t typed_rec;
	} stim_row_t;

	// Directed stimulus: full-scale swings with zero thresholds, full-scale thresholds that
	// can never be exceeded, then a small case where the valley index comes from the switch.
	stim_row_t directed_rows [0:DIR_ROWS-1] = '{
		'{ROW_SAMPLE, 16'd0,     16'd0, 1'b1, 1'b1, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd0,     16'd0, 1'b0, 1'b1, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd32767, 16'd0, 1'b0, 1'b1, 1'b1,
			'{16'sd32767, 32'd2, hpvf_pkg::KIND_START, 6'd0}},
		'{ROW_SAMPLE, 16'h8000,  16'd0, 1'b0, 1'b1, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd32767, 16'd0, 1'b0, 1'b1, 1'b1,
			'{16'sh8000, 32'd3, hpvf_pkg::KIND_VALLEY, 6'd1}},
		'{ROW_SAMPLE, 16'h8000,  16'd0, 1'b0, 1'b1, 1'b1,
			'{16'sd32767, 32'd4, hpvf_pkg::KIND_PEAK, 6'd2}},
		'{ROW_SAMPLE, 16'h8000,  16'd0, 1'b0, 1'b1, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'h8001,  16'd0, 1'b0, 1'b1, 1'b1,
			'{16'sh8000, 32'd5, hpvf_pkg::KIND_VALLEY, 6'd3}},
		'{ROW_THRESH, 16'hFFFF,  16'hFFFF, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'h8000,  16'd0, 1'b1, 1'b1, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd32767, 16'd0, 1'b0, 1'b1, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd0,     16'd0, 1'b0, 1'b1, 1'b0, NO_REC},
		'{ROW_THRESH, 16'd10,    16'd5, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd0,     16'd0, 1'b1, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd10,    16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, -16'sd11,  16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, -16'sd5,   16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd20,    16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd15,    16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd14,    16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd14,    16'd0, 1'b0, 1'b0, 1'b0, NO_REC},
		'{ROW_SAMPLE, 16'd20,    16'd0, 1'b0, 1'b0, 1'b0, NO_REC}
	};

	logic clk;
	logic arst_n;

	hpvf_sample_if sample_ch();
	hpvf_record_if record_ch();
	hpvf_cfg_if    cfg_ch();

	hysteresis_peak_valley_finder_top #(
		.RECORD_SLOTS(RECORD_SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.records (record_ch),
		.cfg     (cfg_ch)
	);

	// Expected tracker state and thresholds.
	hpvf_pkg::phase_t trk_phase;
	int               trk_ref;
	int               trk_max;
	logic [31:0]      trk_max_at;
	int               trk_min;
	logic [31:0]      trk_min_at;
	logic [31:0]      trk_count;
	int               trk_emitted;
	int               thr_start;
	int               thr_peak;

	// Records still awaited from the block, oldest first.
	hpvf_pkg::rec_t extrema_due [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int src_idle_pct   = 0;
	int sink_idle_pct  = 0;
	bit hold_request   = 1'b0;
	bit hold_off       = 1'b0;

	// Expected result given by the directed row now on the sample channel.
	bit             row_typed     = 1'b0;
	bit             row_typed_has = 1'b0;
	hpvf_pkg::rec_t row_typed_rec = '0;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_tracker();
		trk_phase   = hpvf_pkg::PH_REFERENCE;
		trk_ref     = 0;
		trk_max     = 0;
		trk_max_at  = '0;
		trk_min     = 0;
		trk_min_at  = '0;
		trk_count   = '0;
		trk_emitted = 0;
	endfunction

	// Builds a record unless the record store is already full.
	function automatic bit log_record(input int value, input logic [31:0] at,
		input hpvf_pkg::kind_t kind, output hpvf_pkg::rec_t rec);
		rec = '0;
		if (trk_emitted >= RECORD_SLOTS - 1)
			return 1'b0;
		rec.value = value[15:0];
		rec.index = at;
		rec.kind  = kind;
		rec.slot  = trk_emitted[5:0];
		trk_emitted++;
		return 1'b1;
	endfunction

	// Advances the expected tracker by one sample; returns 1 when a record results.
	function automatic bit track_sample(input logic signed [15:0] smp, input logic restart,
		output hpvf_pkg::rec_t rec);
		int s;
		int d;
		int departure;
		bit made;
		s    = smp;
		made = 1'b0;
		rec  = '0;
		if (restart)
			clear_tracker();
		d         = s - trk_ref;
		departure = (d < 0) ? -d : d;
		case (trk_phase)
			hpvf_pkg::PH_REFERENCE: begin
				trk_ref   = s;
				trk_phase = hpvf_pkg::PH_WAIT_START;
			end
			hpvf_pkg::PH_WAIT_START: begin
				if (departure > thr_start) begin
					trk_ref   = s;
					made      = log_record(s, trk_count, hpvf_pkg::KIND_START, rec);
					trk_phase = hpvf_pkg::PH_TREND;
				end
			end
			hpvf_pkg::PH_TREND: begin
				if (departure > thr_peak) begin
					if (d > 0) begin
						trk_max    = s;
						trk_max_at = trk_count;
						trk_phase  = hpvf_pkg::PH_RISING;
					end else begin
						trk_min    = s;
						trk_min_at = trk_count;
						trk_phase  = hpvf_pkg::PH_FALLING;
					end
				end
			end
			hpvf_pkg::PH_RISING: begin
				if (s > trk_max) begin
					trk_max    = s;
					trk_max_at = trk_count;
				end
				if (trk_max - s > thr_peak) begin
					made       = log_record(trk_max, trk_max_at, hpvf_pkg::KIND_PEAK, rec);
					trk_min    = s;
					trk_min_at = trk_count;
					trk_phase  = hpvf_pkg::PH_FALLING;
				end
			end
			hpvf_pkg::PH_FALLING: begin
				if (s < trk_min) begin
					trk_min    = s;
					trk_min_at = trk_count;
				end
				if (s - trk_min > thr_peak) begin
					made       = log_record(trk_min, trk_min_at, hpvf_pkg::KIND_VALLEY, rec);
					trk_max    = s;
					trk_max_at = trk_count;
					trk_phase  = hpvf_pkg::PH_RISING;
				end
			end
			default: begin
			end
		endcase
		trk_count = trk_count + 32'd1;
		return made;
	endfunction

	task automatic flag_record(input bit stray, input hpvf_pkg::rec_t want,
		input hpvf_pkg::rec_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (stray)
				$display("unexpected record: value %0d index %0d kind %0d slot %0d",
					got.value, got.index, got.kind, got.slot);
			else
				$display("record mismatch: want %0d @%0d k%0d s%0d, got %0d @%0d k%0d s%0d",
					want.value, want.index, want.kind, want.slot,
					got.value, got.index, got.kind, got.slot);
		end
	endtask

	// Record transfers are checked first, then threshold and sample transfers update the tracker.
	always @(posedge clk) begin : scoreboard
		hpvf_pkg::rec_t got;
		hpvf_pkg::rec_t want;
		hpvf_pkg::rec_t pred;
		bit             pred_has;
		if (arst_n) begin
			if (record_ch.valid && record_ch.ready) begin
				got.value = record_ch.record_value;
				got.index = record_ch.record_index;
				got.kind  = hpvf_pkg::kind_t'(record_ch.record_kind);
				got.slot  = record_ch.record_slot;
				if (extrema_due.size() == 0) begin
					flag_record(1'b1, NO_REC, got);
				end else begin
					want = extrema_due.pop_front();
					if (got.value !== want.value || got.index !== want.index ||
						got.kind !== want.kind || got.slot !== want.slot)
						flag_record(1'b0, want, got);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					hpvf_pkg::CFG_START_THR: thr_start = int'(cfg_ch.data);
					hpvf_pkg::CFG_PEAK_THR:  thr_peak  = int'(cfg_ch.data);
					default: begin
					end
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				pred_has = track_sample(sample_ch.sample, sample_ch.restart, pred);
				if (row_typed) begin
					pred_has = row_typed_has;
					pred     = row_typed_rec;
				end
				if (pred_has)
					extrema_due.push_back(pred);
			end
		end
	end

	// Receiver readiness: random stalls, forced low during the long hold-off.
	always @(negedge clk) begin : record_sink
		record_ch.ready <= !hold_off && (int'($urandom_range(0, 99)) >= sink_idle_pct);
	end

	// Long receiver hold-off so that the block fills up and stalls its sample input.
	initial begin : record_hold
		wait (hold_request);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Ends a hung run.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one sample, possibly after a random gap, and returns at the falling edge
	// after its transfer with valid still high.
	task automatic send_sample(input logic [15:0] smp, input logic restart, input bit typed,
		input bit typed_has, input hpvf_pkg::rec_t typed_rec);
		while (int'($urandom_range(0, 99)) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_typed         = typed;
		row_typed_has     = typed_has;
		row_typed_rec     = typed_rec;
		sample_ch.valid   <= 1'b1;
		sample_ch.sample  <= smp;
		sample_ch.restart <= restart;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops the sample stream and waits until every awaited record has arrived.
	task automatic drain_and_settle();
		sample_ch.valid <= 1'b0;
		while (extrema_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both thresholds, one transfer each.
	task automatic set_thresholds(input logic [15:0] start_val, input logic [15:0] peak_val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= hpvf_pkg::CFG_START_THR;
		cfg_ch.data  <= start_val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.index <= hpvf_pkg::CFG_PEAK_THR;
		cfg_ch.data  <= peak_val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int          seg;
		int          sent;
		int          seq_len;
		int          k;
		int          level;
		int          dir;
		int          step_max;
		int          run_left;
		int          cur_peak;
		logic [15:0] raw16;
		logic [15:0] smp;
		logic [15:0] start_set;
		logic [15:0] peak_set;
		logic        restart;

		sample_ch.valid   = 1'b0;
		sample_ch.sample  = '0;
		sample_ch.restart = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = hpvf_pkg::CFG_START_THR;
		cfg_ch.data       = '0;
		record_ch.ready   = 1'b0;
		clear_tracker();
		thr_start = 0;
		thr_peak  = 0;
		src_idle_pct  = 21;
		sink_idle_pct = 62;

		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, starting from the reset thresholds.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].op == ROW_THRESH) begin
				drain_and_settle();
				set_thresholds(directed_rows[r].smp, directed_rows[r].aux);
			end else begin
				send_sample(directed_rows[r].smp, directed_rows[r].restart,
					directed_rows[r].typed, directed_rows[r].typed_has,
					directed_rows[r].typed_rec);
			end
		end

		// Random part: segments with their own thresholds, an idling pattern per pair of segments.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			drain_and_settle();
			case (seg)
				0: begin
					start_set = 16'($urandom_range(0, 15));
					peak_set  = 16'($urandom_range(0, 63));
				end
				1: begin
					start_set = 16'($urandom_range(0, 65535));
					peak_set  = 16'($urandom_range(0, 65535));
				end
				2: begin
					start_set = 16'd0;
					peak_set  = 16'd0;
				end
				3: begin
					start_set = 16'($urandom_range(256, 4095));
					peak_set  = 16'($urandom_range(256, 4095));
				end
				4: begin
					start_set = 16'($urandom_range(0, 255));
					peak_set  = 16'($urandom_range(1000, 20000));
				end
				default: begin
					start_set = 16'd1;
					peak_set  = 16'd1;
				end
			endcase
			set_thresholds(start_set, peak_set);
			cur_peak = int'(peak_set);
			case (seg / 2)
				0: begin
					src_idle_pct  = 21;
					sink_idle_pct = 62;
				end
				1: begin
					src_idle_pct  = 62;
					sink_idle_pct = 21;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			if (seg == SEGMENTS - 1)
				hold_request = 1'b1;

			sent = 0;
			while (sent < SEG_ITEMS) begin
				// One waveform: runs up and down with random step sizes scaled to the
				// peak threshold, mixed with full-scale noise and stray restarts.
				seq_len  = int'($urandom_range(20, 160));
				raw16    = 16'($urandom);
				level    = int'($signed(raw16));
				dir      = ($urandom_range(0, 1) == 0) ? 1 : -1;
				step_max = cur_peak / 4 + 2;
				run_left = int'($urandom_range(2, 30));
				for (k = 0; k < seq_len && sent < SEG_ITEMS; k++) begin
					if (k == 0)
						restart = ($urandom_range(0, 99) < 70);
					else
						restart = ($urandom_range(0, 99) < 2);
					if ($urandom_range(0, 99) < 10) begin
						smp = 16'($urandom);
					end else begin
						level = level + dir * int'($urandom_range(0, step_max));
						if (level > 32767) begin
							level = 32767;
							dir   = -1;
						end else if (level < -32768) begin
							level = -32768;
							dir   = 1;
						end
						run_left--;
						if (run_left == 0) begin
							dir      = -dir;
							run_left = int'($urandom_range(2, 30));
						end
						smp = level[15:0];
					end
					send_sample(smp, restart, 1'b0, 1'b0, NO_REC);
					sent++;
				end
			end
		end

		drain_and_settle();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
